@@ rtl/lstu_pkg.sv @@
// Shared widths, register indexes, reset values and controller/datapath
// handshake structs for the soft-threshold coordinate update block.
// No dependencies.
package lstu_pkg;

   localparam int DATA_W    = 32;   // signed Q-format value width
   localparam int MAG_W     = 31;   // unsigned magnitude / register width
   localparam int STEP_W    = 17;   // relaxation step width
   localparam int COORD_W   = 12;   // coordinate index width
   localparam int QUOT_W    = 32;   // quotient bits produced by the divider
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = MAG_W;

   localparam int          FRAC_BITS_DEFAULT = 16;
   localparam int unsigned COORD_COUNT       = 4096;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROX_TERM  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REG_WEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE  = 2'd2;

   // register reset values
   localparam logic [MAG_W-1:0]  PROX_TERM_RESET  = 31'd32768;
   localparam logic [MAG_W-1:0]  REG_WEIGHT_RESET = 31'd65536;
   localparam logic [STEP_W-1:0] STEP_SIZE_RESET  = 17'd65536;

   localparam logic [MAG_W-1:0]  MAG_MAX  = {MAG_W{1'b1}};
   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic load;      // latch the accepted beat, form the denominator
      logic setup;     // overflow precheck, seed the remainders
      logic div_step;  // one restoring step on both divider lanes
      logic post1;     // saturate quotients, form t and p
      logic post2;     // soft threshold
      logic post3;     // distance and its magnitude
      logic mul;       // step times distance magnitude
      logic fin;       // new value, merit, load the result register
   } cmd_type;

   typedef struct packed {
      logic out_busy;  // result register full and not taken this cycle
   } status_type;

endpackage

@@ rtl/lstu_req_if.sv @@
// Request channel of the soft-threshold update block: valid/ready plus
// one coordinate beat. Depends on lstu_pkg.
interface lstu_req_if;
   logic                               valid;
   logic                               ready;
   logic [lstu_pkg::COORD_W-1:0]       coord_index;
   logic signed [lstu_pkg::DATA_W-1:0] x_value;
   logic signed [lstu_pkg::DATA_W-1:0] grad_value;
   logic [lstu_pkg::MAG_W-1:0]         hess_diag;
   logic                               sweep_start;

   modport source (output valid, coord_index, x_value, grad_value, hess_diag, sweep_start,
                   input ready);
   modport sink (input valid, coord_index, x_value, grad_value, hess_diag, sweep_start,
                 output ready);
endinterface

@@ rtl/lstu_rsp_if.sv @@
// Response channel of the soft-threshold update block: valid/ready plus
// one result beat. Depends on lstu_pkg.
interface lstu_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lstu_pkg::COORD_W-1:0]       coord_out;
   logic signed [lstu_pkg::DATA_W-1:0] new_x;
   logic [lstu_pkg::MAG_W-1:0]         dist_mag;
   logic [lstu_pkg::MAG_W-1:0]         running_merit;

   modport source (output valid, coord_out, new_x, dist_mag, running_merit,
                   input ready);
   modport sink (input valid, coord_out, new_x, dist_mag, running_merit,
                 output ready);
endinterface

@@ rtl/lstu_ctrl.sv @@
// Sequencing state machine of the soft-threshold update block.
// Issues datapath commands and owns the request ready. Depends on lstu_pkg.
module lstu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lstu_pkg::status_type status,
   output lstu_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_POST1 = 3'd3;
   localparam logic [2:0] S_POST2 = 3'd4;
   localparam logic [2:0] S_POST3 = 3'd5;
   localparam logic [2:0] S_MUL   = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   localparam int CNT_W = $clog2(lstu_pkg::QUOT_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lstu_pkg::QUOT_W - 1);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = '0;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_POST1;
            end
         end
         S_POST1: begin
            cmd.post1 = 1'b1;
            state_in  = S_POST2;
         end
         S_POST2: begin
            cmd.post2 = 1'b1;
            state_in  = S_POST3;
         end
         S_POST3: begin
            cmd.post3 = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the result register can take the beat
            if (!status.out_busy) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ rtl/lstu_datapath.sv @@
// Datapath of the soft-threshold update block: configuration registers,
// two-lane shared restoring divider, threshold, multiply, saturation,
// merit tracking and result register. Depends on lstu_pkg.
module lstu_datapath #(
   parameter int FRAC_BITS = lstu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lstu_pkg::cmd_type                   cmd,
   output lstu_pkg::status_type                status,
   input  logic                                csr_write_en,
   input  logic [lstu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lstu_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic [lstu_pkg::COORD_W-1:0]        req_coord_index,
   input  logic [lstu_pkg::DATA_W-1:0]         req_x_value,
   input  logic [lstu_pkg::DATA_W-1:0]         req_grad_value,
   input  logic [lstu_pkg::MAG_W-1:0]          req_hess_diag,
   input  logic                                req_sweep_start,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lstu_pkg::COORD_W-1:0]        rsp_coord_out,
   output logic [lstu_pkg::DATA_W-1:0]         rsp_new_x,
   output logic [lstu_pkg::MAG_W-1:0]          rsp_dist_mag,
   output logic [lstu_pkg::MAG_W-1:0]          rsp_running_merit
);

   localparam int DW     = lstu_pkg::DATA_W;
   localparam int MW     = lstu_pkg::MAG_W;
   localparam int SW     = lstu_pkg::STEP_W;
   localparam int QW     = lstu_pkg::QUOT_W;
   localparam int DVD_W  = DW + FRAC_BITS;     // dividend = magnitude << FRAC_BITS
   localparam int DIST_W = DW + 1;
   localparam int PROD_W = SW + DIST_W;
   localparam int PM_W   = PROD_W - FRAC_BITS;
   localparam int SUM_W  = PM_W + 2;

   localparam logic [QW-1:0] Q_LIMIT = {1'b1, {(QW-1){1'b0}}};

   // configuration
   logic [MW-1:0] prox_ff, regw_ff;
   logic [SW-1:0] step_ff;

   // item context
   logic [lstu_pkg::COORD_W-1:0] coord_ff;
   logic [DW-1:0]                x_ff;
   logic                         start_ff, gneg_ff;
   logic [MW-1:0]                den_ff;

   // divider lanes: a = gradient, b = regularization weight
   logic [DVD_W-1:0] dvd_a_ff, dvd_b_ff;
   logic [MW-1:0]    rem_a_ff, rem_b_ff;
   logic [QW-1:0]    quo_a_ff, quo_b_ff;
   logic             ovf_a_ff, ovf_b_ff;

   // post-divide pipeline
   logic [DW-1:0]     t_ff, s_ff;
   logic [MW-1:0]     p_ff;
   logic [DIST_W-1:0] dmag_ff;
   logic              dneg_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [MW-1:0]     dsat_ff;

   logic [MW-1:0] merit_ff, merit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [lstu_pkg::COORD_W-1:0] rsp_coord_ff;
   logic [DW-1:0] rsp_new_x_ff;
   logic [MW-1:0] rsp_dist_ff;

   // load: denominator and dividend magnitudes
   logic [DW-1:0] den_sum, g_mag;
   logic [MW-1:0] den_in;
   logic [lstu_pkg::COORD_W-1:0] coord_in;

   always_comb begin
      den_sum = {1'b0, req_hess_diag} + {1'b0, prox_ff};
      den_in  = den_sum[DW-1] ? lstu_pkg::MAG_MAX : den_sum[MW-1:0];
      if (den_in == '0) begin
         den_in = MW'(1);
      end
      g_mag    = req_grad_value[DW-1] ? (~req_grad_value + 1'b1) : req_grad_value;
      coord_in = lstu_pkg::COORD_W'(32'(req_coord_index) % lstu_pkg::COORD_COUNT);
   end

   // divider step on both lanes
   logic [DW-1:0] trial_a, trial_b, shift_a, shift_b;
   logic          take_a, take_b;

   always_comb begin
      shift_a = {rem_a_ff, dvd_a_ff[QW-1]};
      shift_b = {rem_b_ff, dvd_b_ff[QW-1]};
      trial_a = shift_a - {1'b0, den_ff};
      trial_b = shift_b - {1'b0, den_ff};
      take_a  = shift_a >= {1'b0, den_ff};
      take_b  = shift_b >= {1'b0, den_ff};
   end

   // post1: saturate quotients, t = sat(x - q), p = min(q_b, max)
   logic [QW-1:0]   qa_sat, q32;
   logic [DW:0]     t_wide;
   logic [DW-1:0]   t_in;
   logic [MW-1:0]   p_in;

   always_comb begin
      qa_sat = (ovf_a_ff || (quo_a_ff > Q_LIMIT)) ? Q_LIMIT : quo_a_ff;
      if (gneg_ff) begin
         q32 = ~qa_sat + 1'b1;
      end else begin
         q32 = qa_sat[QW-1] ? lstu_pkg::DATA_MAX : qa_sat;
      end
      t_wide = {x_ff[DW-1], x_ff} - {q32[DW-1], q32};
      if (t_wide[DW] != t_wide[DW-1]) begin
         t_in = t_wide[DW] ? lstu_pkg::DATA_MIN : lstu_pkg::DATA_MAX;
      end else begin
         t_in = t_wide[DW-1:0];
      end
      p_in = (ovf_b_ff || quo_b_ff[QW-1]) ? lstu_pkg::MAG_MAX : quo_b_ff[MW-1:0];
   end

   // post2: soft threshold
   logic [DW-1:0] p_ext, p_neg, s_in;

   always_comb begin
      p_ext = {1'b0, p_ff};
      p_neg = ~p_ext + 1'b1;
      if ($signed(t_ff) >= $signed(p_ext)) begin
         s_in = t_ff - p_ext;
      end else if ($signed(t_ff) <= $signed(p_neg)) begin
         s_in = t_ff + p_ext;
      end else begin
         s_in = '0;
      end
   end

   // post3: distance, kept as sign and magnitude
   logic [DIST_W-1:0] dist_val, dmag_in;

   always_comb begin
      dist_val = {s_ff[DW-1], s_ff} - {x_ff[DW-1], x_ff};
      dmag_in  = dist_val[DIST_W-1] ? (~dist_val + 1'b1) : dist_val;
   end

   // fin: new value and merit
   logic [PM_W-1:0]  pmag;
   logic [SUM_W-1:0] pm_ext, delta, x_ext, nx_wide;
   logic [DW-1:0]    nx;
   logic [MW-1:0]    merit_base;
   logic             nx_fits;

   always_comb begin
      pmag    = prod_ff[PROD_W-1:FRAC_BITS];
      pm_ext  = {2'b00, pmag};
      delta   = dneg_ff ? (~pm_ext + 1'b1) : pm_ext;
      x_ext   = {{(SUM_W-DW){x_ff[DW-1]}}, x_ff};
      nx_wide = x_ext + delta;
      nx_fits = (&nx_wide[SUM_W-1:DW-1]) || !(|nx_wide[SUM_W-1:DW-1]);
      if (nx_fits) begin
         nx = nx_wide[DW-1:0];
      end else begin
         nx = nx_wide[SUM_W-1] ? lstu_pkg::DATA_MIN : lstu_pkg::DATA_MAX;
      end
      merit_base = start_ff ? '0 : merit_ff;
      merit_in   = merit_ff;
      if (cmd.fin) begin
         merit_in = (dsat_ff >= merit_base) ? dsat_ff : merit_base;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         prox_ff      <= lstu_pkg::PROX_TERM_RESET;
         regw_ff      <= lstu_pkg::REG_WEIGHT_RESET;
         step_ff      <= lstu_pkg::STEP_SIZE_RESET;
         merit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               lstu_pkg::CSR_PROX_TERM:  prox_ff <= csr_write_data;
               lstu_pkg::CSR_REG_WEIGHT: regw_ff <= csr_write_data;
               lstu_pkg::CSR_STEP_SIZE:  step_ff <= csr_write_data[SW-1:0];
               default: ;
            endcase
         end
         merit_ff     <= merit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         coord_ff <= coord_in;
         x_ff     <= req_x_value;
         start_ff <= req_sweep_start;
         gneg_ff  <= req_grad_value[DW-1];
         den_ff   <= den_in;
         dvd_a_ff <= {g_mag, {FRAC_BITS{1'b0}}};
         dvd_b_ff <= {1'b0, regw_ff, {FRAC_BITS{1'b0}}};
      end
      if (cmd.setup) begin
         // a quotient of 2^32 or more saturates anyway
         ovf_a_ff <= {{(MW-FRAC_BITS){1'b0}}, dvd_a_ff[DVD_W-1:QW]} >= den_ff;
         ovf_b_ff <= {{(MW-FRAC_BITS){1'b0}}, dvd_b_ff[DVD_W-1:QW]} >= den_ff;
         rem_a_ff <= {{(MW-FRAC_BITS){1'b0}}, dvd_a_ff[DVD_W-1:QW]};
         rem_b_ff <= {{(MW-FRAC_BITS){1'b0}}, dvd_b_ff[DVD_W-1:QW]};
         quo_a_ff <= '0;
         quo_b_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_a_ff <= take_a ? trial_a[MW-1:0] : shift_a[MW-1:0];
         rem_b_ff <= take_b ? trial_b[MW-1:0] : shift_b[MW-1:0];
         quo_a_ff <= {quo_a_ff[QW-2:0], take_a};
         quo_b_ff <= {quo_b_ff[QW-2:0], take_b};
         dvd_a_ff <= {dvd_a_ff[DVD_W-2:0], 1'b0};
         dvd_b_ff <= {dvd_b_ff[DVD_W-2:0], 1'b0};
      end
      if (cmd.post1) begin
         t_ff <= t_in;
         p_ff <= p_in;
      end
      if (cmd.post2) begin
         s_ff <= s_in;
      end
      if (cmd.post3) begin
         dmag_ff <= dmag_in;
         dneg_ff <= dist_val[DIST_W-1];
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(step_ff * dmag_ff);
         dsat_ff <= (dmag_ff > {2'b00, lstu_pkg::MAG_MAX}) ? lstu_pkg::MAG_MAX
                                                             : dmag_ff[MW-1:0];
      end
      if (cmd.fin) begin
         rsp_coord_ff <= coord_ff;
         rsp_new_x_ff <= nx;
         rsp_dist_ff  <= dsat_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_coord_out     = rsp_coord_ff;
   assign rsp_new_x         = rsp_new_x_ff;
   assign rsp_dist_mag      = rsp_dist_ff;
   assign rsp_running_merit = merit_ff;

endmodule

@@ rtl/lasso_soft_threshold_update.sv @@
// Soft-threshold coordinate update: one request beat in, one response beat out.
// The next request is taken only once the previous item has run the 32 restoring
// steps of the shared two-lane divider and reached the response register
// (both quotients share one denominator and run together).
// Reset (synchronous, active high): controller idle, response empty, merit zero,
// registers at prox_term 0.5, reg_weight 1.0, step_size 1.0.
module lasso_soft_threshold_update #(
   parameter int FRAC_BITS = lstu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   lstu_req_if.sink                        req_chan,
   lstu_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_en,
   input  logic [lstu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lstu_pkg::CSR_DATA_W-1:0] csr_write_data
);

   lstu_pkg::cmd_type    cmd;
   lstu_pkg::status_type status;

   // Controller: walks load, precheck, 32 divide steps, threshold, multiply,
   // and holds in the last state while the response register is still full.
   lstu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: the response register parts the two sides, so a finished
   // beat may wait while the next request is taken and worked on.
   lstu_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_coord_index   (req_chan.coord_index),
      .req_x_value       (req_chan.x_value),
      .req_grad_value    (req_chan.grad_value),
      .req_hess_diag     (req_chan.hess_diag),
      .req_sweep_start   (req_chan.sweep_start),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_coord_out     (rsp_chan.coord_out),
      .rsp_new_x         (rsp_chan.new_x),
      .rsp_dist_mag      (rsp_chan.dist_mag),
      .rsp_running_merit (rsp_chan.running_merit)
   );

endmodule

@@ tb/lstu_update_checker.sv @@
// Result checker for the soft-threshold coordinate update block: snoops the
// request, response and register write ports, predicts each result and compares.
// Depends on lstu_pkg, lstu_req_if and lstu_rsp_if.
module lstu_update_checker #(
   parameter int FRAC_BITS = lstu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   lstu_req_if                             req_mon,
   lstu_rsp_if                             rsp_mon,
   input  logic                            csr_write_en,
   input  logic [lstu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lstu_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int                              mismatch_count,
   output int                              pending_beats
);
   timeunit 1ns;
   timeprecision 1ps;

   import lstu_pkg::*;

   localparam longint DATA_HI  = 64'sd2147483647;
   localparam longint DATA_LO  = -64'sd2147483648;
   localparam longint QUOT_CAP = 64'sd2147483648;

   typedef struct {
      logic [COORD_W-1:0]       coord;
      logic signed [DATA_W-1:0] new_x;
      logic [MAG_W-1:0]         dist_mag;
      logic [MAG_W-1:0]         merit;
   } coord_result_type;

   coord_result_type  pending_updates [$];
   coord_result_type  oldest_update;
   logic [MAG_W-1:0]  prox_q;
   logic [MAG_W-1:0]  lambda_q;
   logic [STEP_W-1:0] step_q;
   logic [MAG_W-1:0]  merit_q;
   int                fail_tally = 0;

   function automatic longint sat_data(input longint v);
      if (v > DATA_HI) return DATA_HI;
      if (v < DATA_LO) return DATA_LO;
      return v;
   endfunction

   // (num << FRAC_BITS) / den, magnitude truncated, capped at 2^31
   function automatic longint frac_div(input longint num, input longint den);
      longint mag;
      longint quo;
      mag = (num < 0) ? -num : num;
      quo = (mag <<< FRAC_BITS) / den;
      if (quo > QUOT_CAP) quo = QUOT_CAP;
      return (num < 0) ? -quo : quo;
   endfunction

   function automatic coord_result_type predict_update(input logic [COORD_W-1:0] coord,
                                                       input logic signed [DATA_W-1:0] x_in,
                                                       input logic signed [DATA_W-1:0] g_in,
                                                       input logic [MAG_W-1:0] h_in,
                                                       input logic start);
      longint x, g, den, t, p, s, dist_v, dmag, dsat, scaled, nx;
      coord_result_type r;
      x = x_in;
      g = g_in;
      den = longint'(h_in) + longint'(prox_q);
      if (den > DATA_HI) den = DATA_HI;
      if (den == 0) den = 1;
      t = sat_data(x - sat_data(frac_div(g, den)));
      p = frac_div(longint'(lambda_q), den);
      if (p > DATA_HI) p = DATA_HI;
      if (t >= p) s = t - p;
      else if (t <= -p) s = t + p;
      else s = 0;
      dist_v = s - x;
      dmag = (dist_v < 0) ? -dist_v : dist_v;
      dsat = (dmag > DATA_HI) ? DATA_HI : dmag;
      if (start) merit_q = '0;
      if (dsat >= longint'(merit_q)) merit_q = dsat[MAG_W-1:0];
      scaled = (longint'(step_q) * dmag) >>> FRAC_BITS;
      nx = sat_data((dist_v < 0) ? x - scaled : x + scaled);
      r.coord    = COORD_W'(coord % COORD_COUNT);
      r.new_x    = nx[DATA_W-1:0];
      r.dist_mag = dsat[MAG_W-1:0];
      r.merit    = merit_q;
      return r;
   endfunction

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_updates.delete();
         prox_q     = PROX_TERM_RESET;
         lambda_q   = REG_WEIGHT_RESET;
         step_q     = STEP_SIZE_RESET;
         merit_q    = '0;
         fail_tally = 0;
      end else begin
         // retire first: a beat leaving now belongs to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_updates.size() == 0) begin
               $display("%0t: result expected none got coord %0d new_x %0d", $time,
                        rsp_mon.coord_out, rsp_mon.new_x);
               fail_tally++;
            end else begin
               oldest_update = pending_updates.pop_front();
               check_field("coord_out", oldest_update.coord, rsp_mon.coord_out);
               check_field("new_x", oldest_update.new_x, rsp_mon.new_x);
               check_field("dist_mag", oldest_update.dist_mag, rsp_mon.dist_mag);
               check_field("running_merit", oldest_update.merit, rsp_mon.running_merit);
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_updates.push_back(predict_update(req_mon.coord_index, req_mon.x_value,
                                                     req_mon.grad_value, req_mon.hess_diag,
                                                     req_mon.sweep_start));
         if (csr_write_en) begin
            case (csr_index)
               CSR_PROX_TERM:  prox_q   = csr_write_data;
               CSR_REG_WEIGHT: lambda_q = csr_write_data;
               CSR_STEP_SIZE:  step_q   = csr_write_data[STEP_W-1:0];
               default: ;
            endcase
         end
      end
      mismatch_count <= fail_tally;
      pending_beats  <= pending_updates.size();
   end

endmodule

@@ tb/lasso_soft_threshold_update_tb.sv @@
// Top of the soft-threshold update testbench: clock, reset, request stimulus,
// response stalls, register phases and the verdict. Depends on lstu_pkg, both
// channel interfaces, the block and lstu_update_checker.
module lasso_soft_threshold_update_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lstu_pkg::*;

   localparam int FRAC         = FRAC_BITS_DEFAULT;
   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 48;       // settle time after the final drain
   localparam int CFG_EVERY    = 90;       // items between random register phases

   localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;

   typedef struct {
      logic [COORD_W-1:0]       coord;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] g;
      logic [MAG_W-1:0]         h;
      logic                     start;
   } coord_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic rsp_take = 1'b0;
   int   mismatch_count;
   int   pending_beats;
   int   cycle_count = 0;
   int   burst_left = 0;
   int   stall_mode = 0;
   int   mode_left = 0;

   lstu_req_if req_chan ();
   lstu_rsp_if rsp_chan ();

   assign rsp_chan.ready = rsp_take;

   lasso_soft_threshold_update #(.FRAC_BITS(FRAC)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   lstu_update_checker #(.FRAC_BITS(FRAC)) update_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .pending_beats  (pending_beats)
   );

   initial forever #5 clock = ~clock;

   // Hard stop: far beyond the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lasso_soft_threshold_update_tb: errors");
         $finish;
      end
   end

   // Receiver: pick a stall mode for a random stretch, then hold it.
   // Modes: always take, mostly take, rarely take, sparse periodic takes.
   always @(posedge clock) begin
      if (reset) begin
         rsp_take <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 200);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_take <= 1'b1;
            1: rsp_take <= ($urandom_range(0, 3) != 0);
            2: rsp_take <= ($urandom_range(0, 3) == 0);
            default: rsp_take <= (mode_left % 40 == 0);
         endcase
      end
   end

   function automatic coord_req_type make_beat(input logic [COORD_W-1:0] coord,
                                               input logic signed [DATA_W-1:0] x,
                                               input logic signed [DATA_W-1:0] g,
                                               input logic [MAG_W-1:0] h,
                                               input logic start);
      coord_req_type b;
      b.coord = coord;
      b.x     = x;
      b.g     = g;
      b.h     = h;
      b.start = start;
      return b;
   endfunction

   // Uniform value in [-span, span]
   function automatic logic signed [DATA_W-1:0] near_zero(input int unsigned span);
      return 32'($urandom_range(0, 2 * span)) - 32'(span);
   endfunction

   // Mostly values of a realistic solver scale, a quarter full-range noise.
   function automatic coord_req_type random_beat(input logic [COORD_W-1:0] coord,
                                                 input logic start);
      coord_req_type b;
      b.coord = coord;
      b.start = start;
      if ($urandom_range(0, 3) == 0) begin
         b.x = $urandom;
         b.g = $urandom;
         b.h = 31'($urandom);
      end else begin
         b.x = near_zero(1 << 20);
         b.g = near_zero(1 << 19);
         b.h = ($urandom_range(0, 7) == 0) ? '0 : 31'($urandom_range(0, 1 << 18));
      end
      return b;
   endfunction

   // Present one beat and hold it until the block takes it. Call right after
   // a rising edge; returns at the edge that accepted the beat.
   task automatic send_beat(input coord_req_type b);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid       <= 1'b1;
      req_chan.coord_index <= b.coord;
      req_chan.x_value     <= b.x;
      req_chan.grad_value  <= b.g;
      req_chan.hess_diag   <= b.h;
      req_chan.sweep_start <= b.start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
   endtask

   // Drop valid and hold off until every predicted result has come back.
   task automatic wait_drained;
      req_chan.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_beats != 0);
   endtask

   // Write all three registers on back-to-back cycles; junk in the unused
   // upper bits of the step write must be dropped by the block.
   task automatic write_config(input logic [MAG_W-1:0] prox, input logic [MAG_W-1:0] lam,
                               input logic [STEP_W-1:0] step);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_PROX_TERM;
      csr_write_data <= prox;
      @(posedge clock);
      csr_index      <= CSR_REG_WEIGHT;
      csr_write_data <= lam;
      @(posedge clock);
      csr_index      <= CSR_STEP_SIZE;
      csr_write_data <= {14'($urandom), step};
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic write_random_config;
      logic [MAG_W-1:0]  prox;
      logic [MAG_W-1:0]  lam;
      logic [STEP_W-1:0] step;
      case ($urandom_range(0, 5))
         0: prox = '0;
         1: prox = 31'($urandom);
         2: prox = MAG_MAX;
         default: prox = 31'($urandom_range(1, 1 << 18));
      endcase
      case ($urandom_range(0, 4))
         0: lam = '0;
         1: lam = 31'($urandom);
         default: lam = 31'($urandom_range(0, 1 << 18));
      endcase
      case ($urandom_range(0, 4))
         0: step = '0;
         1: step = 17'($urandom_range(65537, 131071));
         2: step = 17'd65536;
         default: step = 17'($urandom_range(0, 65536));
      endcase
      write_config(prox, lam, step);
   endtask

   initial begin : stimulus
      int items_done;
      int since_cfg;
      int sweep_len;
      logic [COORD_W-1:0] base;
      logic well_formed;
      logic start;

      req_chan.valid       <= 1'b0;
      req_chan.coord_index <= '0;
      req_chan.x_value     <= '0;
      req_chan.grad_value  <= '0;
      req_chan.hess_diag   <= '0;
      req_chan.sweep_start <= 1'b0;
      csr_write_en         <= 1'b0;
      csr_index            <= CSR_PROX_TERM;
      csr_write_data       <= '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero item, field extremes, soft and dead zones.
      send_beat(make_beat(12'd0, 32'sd0, 32'sd0, 31'd0, 1'b1));
      send_beat(make_beat(12'd4095, DATA_MAX, DATA_MIN, 31'd0, 1'b0));
      send_beat(make_beat(12'd1, DATA_MIN, DATA_MAX, MAG_MAX, 1'b0));
      send_beat(make_beat(12'd2, DATA_MAX, DATA_MAX, MAG_MAX, 1'b0));
      send_beat(make_beat(12'd3, DATA_MIN, DATA_MIN, 31'd0, 1'b0));
      send_beat(make_beat(12'd4, Q_ONE, 32'sd16384, 31'd65536, 1'b0));
      send_beat(make_beat(12'd5, 32'sd6554, 32'sd6554, 31'd131072, 1'b0));
      send_beat(make_beat(12'd6, -32'sd196608, Q_ONE, 31'd32768, 1'b0));
      // new sweep with a small distance: merit must restart low
      send_beat(make_beat(12'd0, 32'sd100, 32'sd0, 31'd65536, 1'b1));
      wait_drained();

      // Zero denominator: prox_term 0 with hess_diag 0; step of zero.
      write_config(31'd0, 31'd0, 17'd0);
      send_beat(make_beat(12'd7, 32'sd327680, 32'sd1, 31'd0, 1'b0));
      send_beat(make_beat(12'd8, DATA_MAX, DATA_MIN, 31'd0, 1'b0));
      send_beat(make_beat(12'd9, DATA_MIN, DATA_MAX, 31'd0, 1'b1));
      wait_drained();

      // Largest registers, step above one.
      write_config(MAG_MAX, MAG_MAX, 17'd131071);
      send_beat(make_beat(12'd10, DATA_MAX, DATA_MIN, MAG_MAX, 1'b0));
      send_beat(make_beat(12'd11, DATA_MIN, DATA_MAX, 31'd0, 1'b0));
      send_beat(make_beat(12'd12, -Q_ONE, Q_ONE, 31'd1, 1'b0));
      send_beat(make_beat(12'd13, 32'sd0, DATA_MIN, 31'd0, 1'b0));
      wait_drained();

      // Least prox_term with the largest lambda: threshold saturates.
      write_config(31'd1, MAG_MAX, 17'd65536);
      send_beat(make_beat(12'd14, DATA_MAX, 32'sd0, 31'd0, 1'b1));
      send_beat(make_beat(12'd15, DATA_MIN, 32'sd0, 31'd0, 1'b0));
      send_beat(make_beat(12'd16, Q_ONE, -Q_ONE, 31'd0, 1'b0));
      wait_drained();

      // No regularization, step of one and a half.
      write_config(31'd65536, 31'd0, 17'd98304);
      send_beat(make_beat(12'd17, Q_ONE, 32'sd32768, 31'd65536, 1'b1));
      send_beat(make_beat(12'd18, -32'sd131072, -Q_ONE, 31'd0, 1'b0));
      send_beat(make_beat(12'd19, DATA_MAX, DATA_MIN, 31'd0, 1'b0));

      // Random part: sweeps over consecutive coordinates, started by a flag,
      // with some broken sweeps and stray starts mixed in.
      items_done = 0;
      since_cfg  = CFG_EVERY;
      while (items_done < RANDOM_ITEMS) begin
         if (since_cfg >= CFG_EVERY) begin
            wait_drained();
            write_random_config();
            since_cfg = 0;
         end else if ($urandom_range(0, 39) == 0) begin
            wait_drained();
         end
         sweep_len   = $urandom_range(1, 24);
         base        = 12'($urandom);
         well_formed = ($urandom_range(0, 7) != 0);
         for (int k = 0; k < sweep_len; k++) begin
            if (well_formed) start = (k == 0) || ($urandom_range(0, 29) == 0);
            else start = 1'($urandom);
            // the index wraps past 4095 on purpose
            send_beat(random_beat(base + 12'(k), start));
         end
         items_done += sweep_len;
         since_cfg  += sweep_len;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_beats == 0)
         $display("lasso_soft_threshold_update_tb: clean");
      else
         $display("lasso_soft_threshold_update_tb: errors");
      $finish;
   end

endmodule
